// ===== rtl/stpars_pkg.sv =====
// Shared constants, command codes and controller/datapath interface types for the segment tree unit.
`timescale 1ns / 1ps
`default_nettype none

package stpars_pkg;

	// Default tree size (leaf positions)
	localparam int MAX_LEAVES_DEF = 1024;

	// Field widths
	localparam int CMD_W      = 2;
	localparam int LEAF_W     = 10;
	localparam int DELTA_W    = 17;
	localparam int BOUND_W    = 11;
	localparam int TOTAL_W    = 42;
	localparam int LEAF_VAL_W = 32;

	// leaves_in_use after reset
	localparam logic [BOUND_W-1:0] LEAVES_RESET = 11'd1024;

	// Command codes (cmd / op_done)
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Datapath operation issued by the controller each cycle
	typedef enum logic [2:0] {
		DP_NOP,
		DP_LOAD,
		DP_CLR_STEP,
		DP_LEAF_RD,
		DP_LEAF_WR,
		DP_PATH,
		DP_QRY_STEP,
		DP_RESULT
	} dp_op_t;

	// Datapath status back to the controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             in_tree;
		logic             span_ok;
		logic             path_last;
		logic             q_more;
		logic             clr_last;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/stpars_dp.sv =====
// Datapath of the segment tree unit: node memory, path update, span walk, clear sweep.
`timescale 1ns / 1ps
`default_nettype none

module stpars_dp
	import stpars_pkg::*;
#(
	parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [BOUND_W-1:0]        cfg_wr_data,
	input  wire logic [CMD_W-1:0]          cmd,
	input  wire logic [LEAF_W-1:0]         leaf_index,
	input  wire logic signed [DELTA_W-1:0] delta,
	input  wire logic [BOUND_W-1:0]        range_start,
	input  wire logic [BOUND_W-1:0]        range_end,
	input  wire dp_op_t                    op,
	output dp_status_t                     status,
	output logic [TOTAL_W-1:0]             range_total,
	output logic [CMD_W-1:0]               op_done
);

	localparam int NODES = 2 * MAX_LEAVES;
	localparam int AW    = $clog2(NODES);
	localparam int LW    = (AW > BOUND_W) ? AW : BOUND_W;
	localparam int PW    = LW + 1;

	localparam logic [LW-1:0] MAX_L      = LW'(MAX_LEAVES);
	localparam logic [AW-1:0] NODES_LAST = AW'(NODES - 1);
	localparam logic [AW-1:0] ONE_A      = AW'(1);

	logic [TOTAL_W-1:0] mem [NODES];
	logic [TOTAL_W-1:0] rd_a_q, rd_b_q;

	logic [BOUND_W-1:0]        leaves_in_use_q;
	logic [AW-1:0]             clr_cnt_q;

	logic [CMD_W-1:0]          cmd_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic [AW-1:0]             pos_q;
	logic [PW-1:0]             lo_q, hi_q;
	logic                      in_tree_q, span_ok_q;
	logic [TOTAL_W-1:0]        cur_q, acc_q;
	logic                      take_a_q, take_b_q;
	logic [TOTAL_W-1:0]        range_total_q;
	logic [CMD_W-1:0]          op_done_q;

	// load-time decode
	logic [LW-1:0] liu_ext, lim, end_ext, end_c, start_ext;
	logic [PW-1:0] pos_sum, lo_d, hi_d;
	logic          span_ok_d, in_tree_d;

	// leaf update
	logic signed [LEAF_VAL_W+1:0] leaf_sum;
	logic [LEAF_VAL_W-1:0]        leaf_new;

	// path and span
	logic [AW-1:0]      parent;
	logic [TOTAL_W-1:0] path_sum, acc_next;
	logic [PW-1:0]      hi_m1;
	logic               q_more;

	// memory ports
	logic               wr_en;
	logic [AW-1:0]      wr_addr, rd_a_addr, rd_b_addr;
	logic [TOTAL_W-1:0] wr_data;

	always_comb begin
		liu_ext   = LW'(leaves_in_use_q);
		lim       = (liu_ext > MAX_L) ? MAX_L : liu_ext;
		end_ext   = LW'(range_end);
		end_c     = (end_ext > lim) ? lim : end_ext;
		start_ext = LW'(range_start);
		span_ok_d = start_ext < end_c;
		in_tree_d = LW'(leaf_index) < lim;
		pos_sum   = PW'(LW'(leaf_index)) + PW'(MAX_L);
		lo_d      = PW'(start_ext) + PW'(MAX_L);
		hi_d      = PW'(end_c) + PW'(MAX_L);
	end

	// clamp leaf to [0, 2^32-1]
	always_comb begin
		leaf_sum = $signed({2'b00, rd_a_q[LEAF_VAL_W-1:0]}) + (LEAF_VAL_W + 2)'(delta_q);
		if (leaf_sum[LEAF_VAL_W+1]) begin
			leaf_new = '0;
		end else if (leaf_sum[LEAF_VAL_W]) begin
			leaf_new = '1;
		end else begin
			leaf_new = leaf_sum[LEAF_VAL_W-1:0];
		end
	end

	assign parent   = pos_q >> 1;
	assign path_sum = cur_q + rd_a_q;
	assign q_more   = lo_q < hi_q;
	assign hi_m1    = hi_q - PW'(1);
	assign acc_next = acc_q + (take_a_q ? rd_a_q : '0) + (take_b_q ? rd_b_q : '0);

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = '0;
		rd_a_addr = pos_q;
		rd_b_addr = hi_m1[AW-1:0];
		case (op)
			DP_CLR_STEP: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
			end
			DP_LEAF_WR: begin
				wr_en     = 1'b1;
				wr_data   = TOTAL_W'(leaf_new);
				rd_a_addr = pos_q ^ ONE_A;
			end
			DP_PATH: begin
				wr_en     = 1'b1;
				wr_addr   = parent;
				wr_data   = path_sum;
				rd_a_addr = parent ^ ONE_A;
			end
			DP_QRY_STEP: begin
				rd_a_addr = lo_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// node memory, one write and two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_a_addr];
		rd_b_q <= mem[rd_b_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaves_in_use_q <= LEAVES_RESET;
			clr_cnt_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				leaves_in_use_q <= cfg_wr_data;
			end
			if (op == DP_CLR_STEP) begin
				clr_cnt_q <= (clr_cnt_q == NODES_LAST) ? '0 : clr_cnt_q + ONE_A;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			DP_LOAD: begin
				cmd_q     <= cmd;
				delta_q   <= delta;
				pos_q     <= pos_sum[AW-1:0];
				lo_q      <= lo_d;
				hi_q      <= hi_d;
				in_tree_q <= in_tree_d;
				span_ok_q <= span_ok_d;
				acc_q     <= '0;
				take_a_q  <= 1'b0;
				take_b_q  <= 1'b0;
			end
			DP_LEAF_WR: begin
				cur_q <= TOTAL_W'(leaf_new);
			end
			DP_PATH: begin
				cur_q <= path_sum;
				pos_q <= parent;
			end
			DP_QRY_STEP: begin
				acc_q <= acc_next;
				if (q_more) begin
					take_a_q <= lo_q[0];
					take_b_q <= hi_q[0];
					lo_q     <= (lo_q + PW'(lo_q[0])) >> 1;
					hi_q     <= hi_q >> 1;
				end else begin
					take_a_q <= 1'b0;
					take_b_q <= 1'b0;
				end
			end
			DP_RESULT: begin
				range_total_q <= (cmd_q == CMD_QUERY) ? acc_q : '0;
				op_done_q     <= cmd_q;
			end
			default: begin
			end
		endcase
	end

	assign status.cmd       = cmd_q;
	assign status.in_tree   = in_tree_q;
	assign status.span_ok   = span_ok_q;
	assign status.path_last = parent == ONE_A;
	assign status.q_more    = q_more;
	assign status.clr_last  = clr_cnt_q == NODES_LAST;

	assign range_total = range_total_q;
	assign op_done     = op_done_q;

endmodule

`default_nettype wire

// ===== rtl/stpars_ctrl.sv =====
// Controller of the segment tree unit: sequences each command and owns both handshakes.
`timescale 1ns / 1ps
`default_nettype none

module stpars_ctrl
	import stpars_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire dp_status_t status,
	output dp_op_t          op
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_LEAF_WR,
		S_PATH,
		S_QUERY,
		S_DONE
	} state_t;

	state_t state_q;
	logic   clr_reply_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		case (state_q)
			S_CLEAR:   op = DP_CLR_STEP;
			S_IDLE:    op = in_valid ? DP_LOAD : DP_NOP;
			S_DECODE:  op = (status.cmd == CMD_ADD && status.in_tree) ? DP_LEAF_RD : DP_NOP;
			S_LEAF_WR: op = DP_LEAF_WR;
			S_PATH:    op = DP_PATH;
			S_QUERY:   op = DP_QRY_STEP;
			S_DONE:    op = out_free ? DP_RESULT : DP_NOP;
			default:   op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_reply_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register: filled from DONE, emptied by a transfer
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (status.clr_last) begin
						clr_reply_q <= 1'b0;
						state_q     <= clr_reply_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (status.cmd)
						CMD_ADD:   state_q <= status.in_tree ? S_LEAF_WR : S_DONE;
						CMD_QUERY: state_q <= status.span_ok ? S_QUERY : S_DONE;
						CMD_CLEAR: begin
							clr_reply_q <= 1'b1;
							state_q     <= S_CLEAR;
						end
						default:   state_q <= S_DONE;
					endcase
				end
				S_LEAF_WR: begin
					state_q <= S_PATH;
				end
				S_PATH: begin
					if (status.path_last) begin
						state_q <= S_DONE;
					end
				end
				S_QUERY: begin
					if (!status.q_more) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		(op == DP_RESULT) |-> (!out_valid_q || out_ready))
		else $error("result loaded over an untaken result");

	a_valid_from_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(op == DP_RESULT))
		else $error("out_valid rose without a result load");

	a_path_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PATH && status.path_last) |=> (state_q == S_DONE))
		else $error("path update did not stop at the root");

	a_query_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QUERY && !status.q_more) |=> (state_q == S_DONE))
		else $error("span walk did not stop when the bounds met");

endmodule

`default_nettype wire

// ===== rtl/segment_tree_point_add_range_sum_unit.sv =====
// Top level of the point-add / range-sum segment tree unit.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                 Payload
// in       in_valid / in_ready       cmd, leaf_index, delta, range_start, range_end
// out      out_valid / out_ready     range_total, op_done
// cfg      cfg_wr_en (no wait)       cfg_wr_data -> leaves_in_use
//
// Add: accept, decode, leaf read-modify-write, then the path sums are rewritten
//   level by level up to the root, then result.
// Query: accept, decode, the span walk level by level until the bounds meet, then
//   result. The single node memory has one write and two read ports.
//   An Add to a leaf past leaves_in_use or a Query with an empty span skips to result.
// Clear: the memory is swept one node per cycle, then a result is returned.
// Reset runs the same sweep; in_ready stays low meanwhile.
// One transfer is in flight at a time; a finished result waits in the output
//   register while the next transfer is accepted and worked on.

module segment_tree_point_add_range_sum_unit
	import stpars_pkg::*;
#(
	parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration: leaves_in_use
	input  wire logic                      cfg_wr_en,
	input  wire logic [BOUND_W-1:0]        cfg_wr_data,
	// input channel
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [CMD_W-1:0]          cmd,
	input  wire logic [LEAF_W-1:0]         leaf_index,
	input  wire logic signed [DELTA_W-1:0] delta,
	input  wire logic [BOUND_W-1:0]        range_start,
	input  wire logic [BOUND_W-1:0]        range_end,
	// result channel
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [TOTAL_W-1:0]             range_total,
	output logic [CMD_W-1:0]               op_done
);

	dp_op_t     op;
	dp_status_t status;

	// sequencing and handshakes
	stpars_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.op        (op)
	);

	// node sums live here; leaves at MAX_LEAVES.., internal sums below, root at 1
	stpars_dp #(
		.MAX_LEAVES (MAX_LEAVES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.leaf_index  (leaf_index),
		.delta       (delta),
		.range_start (range_start),
		.range_end   (range_end),
		.op          (op),
		.status      (status),
		.range_total (range_total),
		.op_done     (op_done)
	);

endmodule

`default_nettype wire
